>>> rtl/lws_pkg.sv
// Shared types, constants and helper functions of the LoRa whitening/interleaver core.
package lws_pkg;

  // Field widths fixed by the interface
  localparam int BYTE_W     = 8;
  localparam int SYM_W      = 12;
  localparam int SF_W       = 4;
  localparam int CR_W       = 3;
  localparam int SYMI_W     = $clog2(BYTE_W);
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;

  // Defaults for the top-level parameters
  localparam int MAX_SF_DEF     = 12;
  localparam int WHITEN_LEN_DEF = 512;

  // LoRa constants
  localparam int             MIN_SF    = 7;
  localparam int             RR_BITS   = 2;    // bits dropped per symbol at reduced rate
  localparam int             DATA_SYMS = 4;    // symbols before the parity symbols
  localparam logic [CR_W-1:0] HDR_CR   = 3'd4; // header block always codes at 4/8
  localparam logic [CR_W-1:0] MIN_CR   = 3'd1;
  localparam logic [CR_W-1:0] MAX_CR   = 3'd4;

  // Block job queue between front and back
  localparam int Q_DEPTH = 2;

  // Register reset values
  localparam logic [SF_W-1:0] RST_SF = 4'd7;
  localparam logic [CR_W-1:0] RST_CR = 3'd4;
  localparam logic            RST_RR = 1'b0;
  localparam logic            RST_EH = 1'b1;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SF = 2'd0,
    CFG_CR = 2'd1,
    CFG_RR = 2'd2,
    CFG_EH = 2'd3
  } cfg_reg_t;

  // Channel payloads
  typedef struct packed {
    logic [BYTE_W-1:0] code_byte;
    logic              packet_start;
  } in_item_t;

  typedef struct packed {
    logic [SYM_W-1:0] chirp_symbol;
    logic             block_last;
    logic             from_header;
  } out_item_t;

  // Active (saturated) configuration
  typedef struct packed {
    logic [SF_W-1:0] sf;
    logic [CR_W-1:0] cr;
    logic            rr;
    logic            eh;
  } cfg_t;

  // Per-block control carried from front to back
  typedef struct packed {
    logic [SF_W-1:0] width;  // bits per symbol in this block
    logic [CR_W-1:0] ncr;    // parity symbols
    logic            shift2; // symbols shifted up by RR_BITS
    logic            hdr;    // header block
  } blk_info_t;

  // Bit shuffle: result bit j takes source bit BIT_PERM[j]
  localparam logic [2:0] BIT_PERM [BYTE_W] = '{3'd1, 3'd2, 3'd3, 3'd5, 3'd4, 3'd0, 3'd6, 3'd7};

  function automatic logic [BYTE_W-1:0] bit_shuffle(input logic [BYTE_W-1:0] v);
    logic [BYTE_W-1:0] r;
    for (int j = 0; j < BYTE_W; j++) begin
      r[j] = v[BIT_PERM[j]];
    end
    return r;
  endfunction

  // Gray to binary, log-depth prefix XOR
  function automatic logic [SYM_W-1:0] gray_to_bin(input logic [SYM_W-1:0] x);
    logic [SYM_W-1:0] y;
    y = x;
    y = y ^ (y >> 1);
    y = y ^ (y >> 2);
    y = y ^ (y >> 4);
    y = y ^ (y >> 8);
    return y;
  endfunction

  // Whitening sequence ROM; positions beyond it read zero
  localparam int ROM_LEN = 512;
  localparam int ROM_AW  = 9;

  localparam logic [BYTE_W-1:0] WHITEN_ROM [ROM_LEN] = '{
8'hff,8'hff,8'h2d,8'hff,8'h78,8'hff,8'he1,8'hff,8'h00,8'hff,8'hd2,8'h2d,8'h55,8'h78,8'h4b,8'he1,
8'h66,8'h00,8'h1e,8'hd2,8'hff,8'h55,8'h2d,8'h4b,8'h78,8'h66,8'he1,8'h1e,8'hd2,8'hff,8'h87,8'h2d,
8'hcc,8'h78,8'haa,8'he1,8'hb4,8'hd2,8'h99,8'h87,8'he1,8'hcc,8'h00,8'haa,8'h00,8'hb4,8'h00,8'h99,
8'h00,8'he1,8'hd2,8'h00,8'h55,8'h00,8'h99,8'h00,8'he1,8'h00,8'hd2,8'hd2,8'h87,8'h55,8'h1e,8'h99,
8'h2d,8'he1,8'h78,8'hd2,8'he1,8'h87,8'hd2,8'h1e,8'h55,8'h2d,8'h99,8'h78,8'h33,8'he1,8'h55,8'hd2,
8'h4b,8'h55,8'h66,8'h99,8'h1e,8'h33,8'h2d,8'h55,8'h78,8'h4b,8'he1,8'h66,8'h00,8'h1e,8'h00,8'h2d,
8'h00,8'h78,8'hd2,8'he1,8'h87,8'h00,8'hcc,8'h00,8'h78,8'h00,8'h33,8'hd2,8'h55,8'h87,8'h99,8'hcc,
8'h33,8'h78,8'h55,8'h33,8'h99,8'h55,8'h33,8'h99,8'h87,8'h33,8'hcc,8'h55,8'haa,8'h99,8'h66,8'h33,
8'h1e,8'h87,8'h2d,8'hcc,8'h78,8'haa,8'h33,8'h66,8'h55,8'h1e,8'h99,8'h2d,8'he1,8'h78,8'h00,8'h33,
8'h00,8'h55,8'hd2,8'h99,8'h55,8'he1,8'h4b,8'h00,8'hb4,8'h00,8'h4b,8'hd2,8'h66,8'h55,8'hcc,8'h4b,
8'haa,8'hb4,8'h66,8'h4b,8'hcc,8'h66,8'haa,8'hcc,8'hb4,8'haa,8'h4b,8'h66,8'h66,8'hcc,8'hcc,8'haa,
8'h78,8'hb4,8'h33,8'h4b,8'h55,8'h66,8'h4b,8'hcc,8'h66,8'h78,8'hcc,8'h33,8'h78,8'h55,8'he1,8'h4b,
8'h00,8'h66,8'hd2,8'hcc,8'h87,8'h78,8'h1e,8'he1,8'hff,8'h00,8'hff,8'hd2,8'h2d,8'h87,8'haa,8'h1e,
8'h66,8'hff,8'hcc,8'hff,8'haa,8'h2d,8'h66,8'haa,8'h1e,8'h66,8'hff,8'hcc,8'h2d,8'haa,8'haa,8'h66,
8'hb4,8'h1e,8'h4b,8'hff,8'h66,8'h2d,8'h1e,8'haa,8'h2d,8'hb4,8'haa,8'h4b,8'hb4,8'h66,8'h99,8'h1e,
8'he1,8'h2d,8'hd2,8'haa,8'h55,8'hb4,8'h99,8'h99,8'he1,8'he1,8'h00,8'hd2,8'hd2,8'h55,8'h87,8'h99,
8'hcc,8'he1,8'haa,8'h00,8'h66,8'hd2,8'hcc,8'h87,8'h78,8'hcc,8'he1,8'haa,8'hd2,8'h66,8'h87,8'hcc,
8'h1e,8'h78,8'hff,8'he1,8'h2d,8'hd2,8'h78,8'h87,8'h33,8'h1e,8'h87,8'hff,8'h1e,8'h2d,8'h2d,8'h78,
8'h78,8'h33,8'h33,8'h87,8'h87,8'h1e,8'hcc,8'h2d,8'h78,8'h78,8'he1,8'h33,8'hd2,8'h87,8'h55,8'hcc,
8'h4b,8'h78,8'h66,8'he1,8'hcc,8'hd2,8'haa,8'h55,8'hb4,8'h4b,8'h99,8'h66,8'h33,8'hcc,8'h55,8'haa,
8'h99,8'hb4,8'he1,8'h99,8'hd2,8'h33,8'h55,8'h55,8'h4b,8'h99,8'hb4,8'he1,8'h99,8'hd2,8'h33,8'h55,
8'h55,8'h4b,8'h4b,8'hb4,8'hb4,8'h99,8'h4b,8'h33,8'hb4,8'h55,8'h99,8'h4b,8'h33,8'hb4,8'h87,8'h4b,
8'h1e,8'hb4,8'h2d,8'h99,8'haa,8'h33,8'h66,8'hc7,8'h1e,8'h1e,8'h2d,8'h2d,8'haa,8'haa,8'h66,8'h66,
8'hcc,8'h1e,8'h78,8'h2d,8'h33,8'haa,8'h87,8'h66,8'h1e,8'hcc,8'hff,8'h78,8'h2d,8'h33,8'haa,8'h87,
8'h66,8'h1e,8'h1e,8'hff,8'hff,8'h2d,8'hff,8'haa,8'hff,8'h66,8'h2d,8'h1e,8'haa,8'hff,8'hb4,8'hff,
8'h99,8'hff,8'h33,8'h2d,8'h87,8'haa,8'hcc,8'hb4,8'h78,8'h99,8'h33,8'h33,8'h87,8'h87,8'hcc,8'hcc,
8'haa,8'h78,8'hb4,8'h33,8'h4b,8'h87,8'hb4,8'hcc,8'h99,8'haa,8'he1,8'hb4,8'hd2,8'h4b,8'h87,8'hb4,
8'hcc,8'h99,8'h78,8'he1,8'he1,8'hd2,8'h00,8'h87,8'h00,8'hcc,8'hd2,8'h78,8'h87,8'he1,8'h1e,8'h00,
8'h2d,8'h00,8'haa,8'hd2,8'hb4,8'h87,8'h4b,8'h1e,8'hb4,8'h2d,8'h4b,8'haa,8'hb4,8'hb4,8'h4b,8'h4b,
8'h66,8'hb4,8'h1e,8'h4b,8'hff,8'hb4,8'hff,8'h4b,8'h2d,8'h66,8'h78,8'h1e,8'h33,8'hff,8'h55,8'hff,
8'h4b,8'h2d,8'hb4,8'h78,8'h99,8'h33,8'he1,8'h55,8'h00,8'h4b,8'hd2,8'hb4,8'h55,8'h99,8'h99,8'he1,
8'h33,8'h00,8'h87,8'hd2,8'h1e,8'h55,8'hff,8'h99,8'hff,8'h33,8'hff,8'h87,8'hff,8'h1e,8'h00,8'h00
  };

endpackage

>>> rtl/lws_front.sv
// Front end: byte acceptance, block classification, whitening, bit shuffle and block buffer.
module lws_front import lws_pkg::*; #(
  parameter int MAX_SF     = MAX_SF_DEF,
  parameter int WHITEN_LEN = WHITEN_LEN_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  cfg_t                           cfg,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  in_item_t                       in_data,
  input  logic                           q_full,
  output logic                           push,
  output blk_info_t                      push_info,
  output logic [MAX_SF-1:0][BYTE_W-1:0]  push_bytes
);

  localparam int CNT_W = $clog2(MAX_SF + 1);
  localparam int IDX_W = $clog2(MAX_SF);
  localparam int POS_W = $clog2(WHITEN_LEN);

  // Block / packet state
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic              hblk_r, hblk_nxt;

  // Shuffle stage
  logic              s1_valid_r, s1_valid_nxt;
  logic [BYTE_W-1:0] s1_byte_r;
  logic              s1_rom_use_r;
  logic [IDX_W-1:0]  s1_idx_r;
  logic              s1_done_r;
  blk_info_t         s1_info_r;
  logic [BYTE_W-1:0] rom_q_r;
  logic [BYTE_W-1:0] buf_r [MAX_SF];

  logic              accept;
  logic              s1_go;
  logic [CNT_W-1:0]  cnt_base, cnt_inc;
  logic [POS_W-1:0]  pos_base, pos_adv;
  logic              hblk_base;
  logic              hdr, narrow, done, rom_use;
  blk_info_t         info;
  logic [BYTE_W-1:0] wbyte, shuf;

  // Handshake: only a finished block facing a full queue holds the stage
  assign in_stall = s1_valid_r && s1_done_r && q_full;
  assign accept   = in_valid && !in_stall;
  assign s1_go    = s1_valid_r && !in_stall;

  // Classify the incoming byte against the current block state
  always_comb begin
    cnt_base    = in_data.packet_start ? '0 : cnt_r;
    pos_base    = in_data.packet_start ? '0 : pos_r;
    hblk_base   = in_data.packet_start ? 1'b1 : hblk_r;
    hdr         = hblk_base && cfg.eh;
    narrow      = hdr || cfg.rr;
    info.width  = narrow ? (cfg.sf - SF_W'(RR_BITS)) : cfg.sf;
    info.ncr    = hdr ? HDR_CR : cfg.cr;
    info.shift2 = narrow;
    info.hdr    = hdr;
    cnt_inc     = cnt_base + 1'b1;
    done        = (SF_W'(cnt_inc) >= info.width);
    rom_use     = !hdr && (32'(pos_base) < ROM_LEN);
    pos_adv     = (pos_base == POS_W'(WHITEN_LEN - 1)) ? '0 : pos_base + 1'b1;
  end

  // Next state of the counters
  always_comb begin
    cnt_nxt      = cnt_r;
    pos_nxt      = pos_r;
    hblk_nxt     = hblk_r;
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      cnt_nxt      = done ? '0 : cnt_inc;
      pos_nxt      = hdr ? pos_base : pos_adv;
      hblk_nxt     = hblk_base && !(done && hdr);
      s1_valid_nxt = 1'b1;
    end else if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      pos_r      <= '0;
      hblk_r     <= 1'b1;
      s1_valid_r <= 1'b0;
    end else begin
      cnt_r      <= cnt_nxt;
      pos_r      <= pos_nxt;
      hblk_r     <= hblk_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // Stage payload and registered whitening ROM read
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_byte_r    <= in_data.code_byte;
      s1_rom_use_r <= rom_use;
      s1_idx_r     <= IDX_W'(cnt_base);
      s1_done_r    <= done;
      s1_info_r    <= info;
      rom_q_r      <= WHITEN_ROM[ROM_AW'(pos_base)];
    end
  end

  // Whiten and shuffle
  always_comb begin
    wbyte = s1_byte_r ^ (s1_rom_use_r ? rom_q_r : '0);
    shuf  = bit_shuffle(wbyte);
  end

  // Block buffer
  always_ff @(posedge clk) begin
    if (s1_go) begin
      buf_r[s1_idx_r] <= shuf;
    end
  end

  // Hand a full block to the queue, newest byte merged in
  assign push      = s1_go && s1_done_r;
  assign push_info = s1_info_r;

  always_comb begin
    for (int b = 0; b < MAX_SF; b++) begin
      push_bytes[b] = (IDX_W'(b) == s1_idx_r) ? shuf : buf_r[b];
    end
  end

  // Byte count never reaches the buffer depth between blocks
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r < CNT_W'(MAX_SF))
    else $error("block byte count out of range");

  // A finished block blocked by a full queue stays in the stage
  a_block_held: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_done_r && q_full) |=> (s1_valid_r && s1_done_r))
    else $error("finished block lost while queue full");

endmodule

>>> rtl/lws_queue.sv
// Short queue of finished interleaver blocks between front and back.
module lws_queue import lws_pkg::*; #(
  parameter int MAX_SF = MAX_SF_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           push,
  input  blk_info_t                      push_info,
  input  logic [MAX_SF-1:0][BYTE_W-1:0]  push_bytes,
  output logic                           full,
  input  logic                           pop,
  output logic                           head_valid,
  output blk_info_t                      head_info,
  output logic [MAX_SF-1:0][BYTE_W-1:0]  head_bytes
);

  localparam int QPTR_W = $clog2(Q_DEPTH);
  localparam int QCNT_W = $clog2(Q_DEPTH + 1);

  blk_info_t                      info_q_r  [Q_DEPTH];
  logic [MAX_SF-1:0][BYTE_W-1:0]  bytes_q_r [Q_DEPTH];
  logic [QPTR_W-1:0]              wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]              rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]              count_r, count_nxt;

  assign full       = (count_r == QCNT_W'(Q_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_info  = info_q_r[rd_ptr_r];
  assign head_bytes = bytes_q_r[rd_ptr_r];

  // Pointer and occupancy update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      info_q_r[wr_ptr_r]  <= push_info;
      bytes_q_r[wr_ptr_r] <= push_bytes;
    end
  end

  // Occupancy bounded, and no pop from an empty queue
  a_q_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r <= QCNT_W'(Q_DEPTH)) && !(pop && (count_r == '0)))
    else $error("block queue over- or underflow");

endmodule

>>> rtl/lws_back.sv
// Back end: diagonal transpose, rotation, Gray mapping and symbol output register.
module lws_back import lws_pkg::*; #(
  parameter int MAX_SF = MAX_SF_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           head_valid,
  input  blk_info_t                      head_info,
  input  logic [MAX_SF-1:0][BYTE_W-1:0]  head_bytes,
  output logic                           pop,
  output logic                           out_valid,
  input  logic                           out_stall,
  output out_item_t                      out_data
);

  localparam int SC_W = SYMI_W + 1;

  logic [SYMI_W-1:0] sym_r, sym_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r;

  logic              go, last;
  logic [MAX_SF-1:0] col, mask, rotl;
  logic [SF_W-1:0]   s_ext, rot;
  logic [SYM_W-1:0]  g, sym_val;

  assign go  = head_valid && (!out_valid_r || !out_stall);
  assign pop = go && last;

  // One symbol: column of bit sym_r, rotate within width, Gray decode
  always_comb begin
    for (int b = 0; b < MAX_SF; b++) begin
      mask[b] = (SF_W'(b) < head_info.width);
      col[b]  = mask[b] && head_bytes[b][sym_r];
    end
    s_ext = SF_W'(sym_r);
    if (sym_r == '0) begin
      rot = '0;
    end else if (s_ext <= head_info.width) begin
      rot = head_info.width - s_ext;
    end else begin
      rot = SF_W'({head_info.width, 1'b0} - {1'b0, s_ext});
    end
    rotl    = ((col << rot) | (col >> (head_info.width - rot))) & mask;
    g       = gray_to_bin(SYM_W'(rotl));
    sym_val = head_info.shift2 ? (g << RR_BITS) : g;
    last    = ((SC_W'(sym_r) + 1'b1) == (SC_W'(DATA_SYMS) + SC_W'(head_info.ncr)));
  end

  // Symbol counter and output register control
  always_comb begin
    sym_nxt       = sym_r;
    out_valid_nxt = out_valid_r;
    if (go) begin
      sym_nxt       = last ? '0 : sym_r + 1'b1;
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sym_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      sym_r       <= sym_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      out_data_r.chirp_symbol <= sym_val;
      out_data_r.block_last   <= last;
      out_data_r.from_header  <= head_info.hdr;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Retiring a block restarts the symbol count
  a_sym_restart: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> (sym_r == '0))
    else $error("symbol counter not restarted after block");

endmodule

>>> rtl/lora_whiten_shuffle_interleave_core.sv
// Top level of the LoRa whitening, bit shuffle, diagonal interleaver and Gray mapper.
//
//  Channel | Direction | Handshake            | Payload
//  in_     | input     | in_valid / in_stall  | in_item_t  (code_byte, packet_start)
//  out_    | output    | out_valid / out_stall| out_item_t (chirp_symbol, block_last, from_header)
//  cfg_    | input     | cfg_we               | cfg_index, cfg_wdata (write only)
//
//  A byte is taken each cycle in_stall is low; a completed block of sf' bytes yields 4+cr
//  symbols (8 for the header block), one per cycle while out_stall is low, from the back
//  end's symbol counter, while the front end fills the next block. out_valid of the first
//  symbol rises once the block has passed the shuffle stage register and the queue.
//  Reset (synchronous, rst_n low) clears counters, queue and output valid; no clearing pass.
//  out_stall holds the output register; up to two finished blocks queue up behind it,
//  after which in_stall rises while a finished block waits in the front end.
module lora_whiten_shuffle_interleave_core import lws_pkg::*; #(
  parameter int MAX_SF     = MAX_SF_DEF,
  parameter int WHITEN_LEN = WHITEN_LEN_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data
);

  cfg_t                           cfg_r, cfg_nxt;
  logic                           q_full, push, pop, head_valid;
  blk_info_t                      push_info, head_info;
  logic [MAX_SF-1:0][BYTE_W-1:0]  push_bytes, head_bytes;

  // Configuration registers, saturated to the supported range on write
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_SF: begin
          if (cfg_wdata < SF_W'(MIN_SF)) begin
            cfg_nxt.sf = SF_W'(MIN_SF);
          end else if (cfg_wdata > SF_W'(MAX_SF)) begin
            cfg_nxt.sf = SF_W'(MAX_SF);
          end else begin
            cfg_nxt.sf = cfg_wdata;
          end
        end
        CFG_CR: begin
          if (cfg_wdata[CR_W-1:0] < MIN_CR) begin
            cfg_nxt.cr = MIN_CR;
          end else if (cfg_wdata[CR_W-1:0] > MAX_CR) begin
            cfg_nxt.cr = MAX_CR;
          end else begin
            cfg_nxt.cr = cfg_wdata[CR_W-1:0];
          end
        end
        CFG_RR: begin
          cfg_nxt.rr = cfg_wdata[0];
        end
        CFG_EH: begin
          cfg_nxt.eh = cfg_wdata[0];
        end
        default: begin
          cfg_nxt = cfg_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sf <= RST_SF;
      cfg_r.cr <= RST_CR;
      cfg_r.rr <= RST_RR;
      cfg_r.eh <= RST_EH;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  lws_front #(
    .MAX_SF     (MAX_SF),
    .WHITEN_LEN (WHITEN_LEN)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .q_full     (q_full),
    .push       (push),
    .push_info  (push_info),
    .push_bytes (push_bytes)
  );

  lws_queue #(
    .MAX_SF (MAX_SF)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_info  (push_info),
    .push_bytes (push_bytes),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_info  (head_info),
    .head_bytes (head_bytes)
  );

  lws_back #(
    .MAX_SF (MAX_SF)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_info  (head_info),
    .head_bytes (head_bytes),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

>>> dv/lws_symbol_checker.sv
// Channel monitor, chirp symbol predictor and scoreboard for the LoRa whitening/interleaver core.
module lws_symbol_checker import lws_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  in_item_t              in_data,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  out_item_t             out_data,
  output int                    mismatches,
  output int                    n_expected
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow copy of the configuration registers, as written
  logic [SF_W-1:0] sf_reg;
  logic [CR_W-1:0] cr_reg;
  logic            rr_reg;
  logic            eh_reg;

  // Predicted block state
  logic [BYTE_W-1:0] blk_buf [MAX_SF_DEF];
  int unsigned       fill_cnt;
  int unsigned       white_pos;
  bit                hdr_open;

  out_item_t pending_symbols [$];
  out_item_t want;
  int        errs;

  // Whiten, shuffle and buffer one code byte; queue the symbols of a completed block
  task automatic interleave_byte(input in_item_t it);
    int unsigned sf, cr, width, ncr, nsym, rot, col, mask, bin;
    bit hdr, shift2;
    logic [BYTE_W-1:0] v;
    out_item_t sym;
    sf = sf_reg;
    if (sf < MIN_SF) sf = MIN_SF;
    if (sf > MAX_SF_DEF) sf = MAX_SF_DEF;
    cr = cr_reg;
    if (cr < MIN_CR) cr = MIN_CR;
    if (cr > MAX_CR) cr = MAX_CR;
    if (it.packet_start) begin
      fill_cnt  = 0;
      white_pos = 0;
      hdr_open  = 1'b1;
    end
    v   = it.code_byte;
    hdr = hdr_open && eh_reg;
    if (hdr) begin
      width  = sf - RR_BITS;
      ncr    = HDR_CR;
      shift2 = 1'b1;
    end else begin
      width  = rr_reg ? sf - RR_BITS : sf;
      ncr    = cr;
      shift2 = rr_reg;
      if (white_pos < ROM_LEN) v = v ^ WHITEN_ROM[white_pos];
      white_pos = (white_pos + 1) % WHITEN_LEN_DEF;
    end
    // fixed bit shuffle
    blk_buf[fill_cnt % MAX_SF_DEF] = {v[7], v[6], v[0], v[4], v[5], v[3], v[2], v[1]};
    fill_cnt++;
    if (fill_cnt >= width) begin
      nsym = DATA_SYMS + ncr;
      mask = (1 << width) - 1;
      for (int s = 0; s < nsym; s++) begin
        // diagonal read: bit b of the symbol is bit s of byte b
        col = 0;
        for (int b = 0; b < width; b++) begin
          if (blk_buf[b][s]) col = col | (1 << b);
        end
        rot = (2 * width - s) % width;
        col = ((col << rot) | (col >> (width - rot))) & mask;
        // Gray decode: every bit XORs in all bits above it
        bin = col;
        for (int k = 1; k < SYM_W; k++) bin = bin ^ (col >> k);
        if (shift2) bin = bin << RR_BITS;
        sym.chirp_symbol = SYM_W'(bin);
        sym.block_last   = (s == nsym - 1);
        sym.from_header  = hdr;
        pending_symbols.push_back(sym);
      end
      fill_cnt = 0;
      if (hdr) hdr_open = 1'b0;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      sf_reg    = RST_SF;
      cr_reg    = RST_CR;
      rr_reg    = RST_RR;
      eh_reg    = RST_EH;
      fill_cnt  = 0;
      white_pos = 0;
      hdr_open  = 1'b1;
      pending_symbols.delete();
    end else begin
      // register writes
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          CFG_SF: sf_reg = cfg_wdata[SF_W-1:0];
          CFG_CR: cr_reg = cfg_wdata[CR_W-1:0];
          CFG_RR: rr_reg = cfg_wdata[0];
          CFG_EH: eh_reg = cfg_wdata[0];
          default: ;
        endcase
      end
      // input transaction
      if (in_valid && !in_stall) interleave_byte(in_data);
      // output transaction against the oldest prediction
      if (out_valid && !out_stall) begin
        if (pending_symbols.size() == 0) begin
          $error("chirp_symbol: expected none, actual %0d", out_data.chirp_symbol);
          errs++;
        end else begin
          want = pending_symbols.pop_front();
          if (out_data.chirp_symbol !== want.chirp_symbol) begin
            $error("chirp_symbol: expected %0d, actual %0d",
                   want.chirp_symbol, out_data.chirp_symbol);
            errs++;
          end
          if (out_data.block_last !== want.block_last) begin
            $error("block_last: expected %0d, actual %0d", want.block_last, out_data.block_last);
            errs++;
          end
          if (out_data.from_header !== want.from_header) begin
            $error("from_header: expected %0d, actual %0d",
                   want.from_header, out_data.from_header);
            errs++;
          end
        end
      end
    end
    mismatches <= errs;
    n_expected <= pending_symbols.size();
  end

endmodule

>>> dv/tb_lora_whiten_shuffle_interleave_core.sv
// Testbench top: clock, reset, stimulus, output back-pressure and verdict for the core.
module tb_lora_whiten_shuffle_interleave_core;
  timeunit 1ns;
  timeprecision 1ps;
  import lws_pkg::*;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_item_t             out_data;
  int                    mismatches;
  int                    n_expected;

  bit gapless;      // both sides send/accept without idle cycles
  int hold_req;     // bumped by stimulus to ask for one long output hold-off
  int hold_done;
  int items_sent;
  int cur_sf;       // saturated sf as last written
  bit cur_rr;
  bit cur_eh;

  // Header block, payload block, a partial block cut by a new packet, second header
  localparam logic [7:0] DIR_BYTES [19] = '{
    8'h00, 8'hFF, 8'hA5, 8'h5A, 8'h80,
    8'hFF, 8'h00, 8'h01, 8'h80, 8'h7F, 8'hFE, 8'h55,
    8'h12, 8'h34,
    8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF
  };

  lora_whiten_shuffle_interleave_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  lws_symbol_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .mismatches (mismatches),
    .n_expected (n_expected)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  task write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task set_config(input logic [3:0] sf_w, input logic [3:0] cr_w,
                  input logic [3:0] rr_w, input logic [3:0] eh_w);
    write_reg(CFG_SF, sf_w);
    write_reg(CFG_CR, cr_w);
    write_reg(CFG_RR, rr_w);
    write_reg(CFG_EH, eh_w);
    cur_sf = (sf_w < MIN_SF) ? MIN_SF : (sf_w > MAX_SF_DEF) ? MAX_SF_DEF : sf_w;
    cur_rr = rr_w[0];
    cur_eh = eh_w[0];
  endtask

  // One input transaction; valid stays up for back-to-back bytes
  task send_code_byte(input in_item_t it);
    int gap;
    gap = gapless ? 0 : $urandom_range(0, 12);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data  <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // Mostly whole blocks: header (on a fresh packet) plus 1-2 payload blocks,
  // sometimes a dropped partial tail, with rare stray packet starts
  task send_packet(input bit with_start);
    int n;
    int pay_w;
    in_item_t it;
    pay_w = cur_rr ? cur_sf - RR_BITS : cur_sf;
    n = pay_w * $urandom_range(1, 2);
    if (with_start && cur_eh) n += cur_sf - RR_BITS;
    if ($urandom_range(0, 3) == 0) n += $urandom_range(1, pay_w - 1);
    for (int i = 0; i < n; i++) begin
      it.packet_start = (i == 0) ? with_start : ($urandom_range(0, 39) == 0);
      case ($urandom_range(0, 7))
        0:       it.code_byte = 8'h00;
        1:       it.code_byte = 8'hFF;
        default: it.code_byte = 8'($urandom);
      endcase
      send_code_byte(it);
    end
  endtask

  // Drop valid, wait for every predicted symbol, then let a partial block settle
  task drain_and_settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (n_expected != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Output side: random stall per transaction, one long hold-off on request
  initial begin : sink
    int hold;
    out_stall = 1'b0;
    forever begin
      if (hold_req != hold_done) begin
        hold = 400;
        hold_done++;
      end else begin
        hold = gapless ? 0 : $urandom_range(0, 12);
      end
      @(negedge clk);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin : stimulus
    in_item_t it;
    logic [3:0] sf_w, cr_w, rr_w, eh_w;
    int base;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_valid  = 1'b0;
    in_data   = '0;
    gapless   = 1'b0;
    cur_sf    = RST_SF;
    cur_rr    = RST_RR;
    cur_eh    = RST_EH;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed bytes at reset configuration
    for (int i = 0; i < 19; i++) begin
      it.code_byte    = DIR_BYTES[i];
      it.packet_start = (i == 0) || (i == 14);
      send_code_byte(it);
    end
    drain_and_settle();

    // configuration phases, extremes first; some phases continue a partial block
    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: begin sf_w = 4'd12; cr_w = 4'd1;  rr_w = 4'd0;  eh_w = 4'd0;  end
        1: begin sf_w = 4'd12; cr_w = 4'd4;  rr_w = 4'd1;  eh_w = 4'd1;  end
        2: begin sf_w = 4'd7;  cr_w = 4'd1;  rr_w = 4'd1;  eh_w = 4'd1;  end
        3: begin sf_w = 4'd0;  cr_w = 4'd0;  rr_w = 4'd0;  eh_w = 4'd1;  end
        4: begin sf_w = 4'd15; cr_w = 4'd15; rr_w = 4'd15; eh_w = 4'd14; end
        default: begin
          sf_w = 4'($urandom);
          cr_w = 4'($urandom);
          rr_w = 4'($urandom);
          eh_w = 4'($urandom);
        end
      endcase
      set_config(sf_w, cr_w, rr_w, eh_w);
      gapless = (ph == 2) || (ph == 7);
      // fill the block queue behind a long output hold-off; enough bytes
      // to back up into the input even at the widest blocks
      if (ph == 5) begin
        gapless = 1'b1;
        hold_req++;
      end
      base = items_sent;
      send_packet($urandom_range(0, 1));
      while (items_sent < base + ((ph == 5) ? 72 : 16)) send_packet(1'b1);
      gapless = 1'b0;
      drain_and_settle();
    end

    // one payload-only packet of seven-byte blocks, back to back
    set_config(4'd7, 4'd1, 4'd0, 4'd0);
    gapless = 1'b1;
    for (int i = 0; i < 28; i++) begin
      it.packet_start = (i == 0);
      it.code_byte    = 8'($urandom);
      send_code_byte(it);
    end
    gapless = 1'b0;
    drain_and_settle();
    repeat (10) @(posedge clk);

    if (mismatches == 0 && n_expected == 0) begin
      $display("lora_whiten_shuffle_interleave_core: match");
    end else begin
      $display("lora_whiten_shuffle_interleave_core: mismatch");
    end
    $finish;
  end

  // watchdog
  initial begin
    #8_000_000;
    $display("lora_whiten_shuffle_interleave_core: mismatch");
    $finish;
  end

endmodule
